// File: hdl/lhd_pkg.sv
package lhd_pkg;

	localparam int COUNT_WIDTH = 32;
	localparam int OUT_WIDTH   = 32;
	localparam int LETTER_W    = 5;
	localparam int ALPHA       = 'h7a - 'h61 + 1;
	localparam int PAIR_DEPTH  = ALPHA * ALPHA;
	localparam int PAIR_AW     = $clog2(PAIR_DEPTH);
	localparam int Q_DEPTH     = 4;
	localparam int OUT_DEPTH   = 4;

	localparam logic [1:0] CMD_COUNT     = 2'd0;
	localparam logic [1:0] CMD_RD_LETTER = 2'd1;
	localparam logic [1:0] CMD_RD_PAIR   = 2'd2;

	localparam logic [7:0] CH_UP_A = 8'h41;
	localparam logic [7:0] CH_UP_Z = 8'h5a;
	localparam logic [7:0] CH_LO_A = 8'h61;
	localparam logic [7:0] CH_LO_Z = 8'h7a;

	typedef enum logic [1:0] {
		OP_BUMP      = 2'd0,
		OP_RD_LETTER = 2'd1,
		OP_RD_PAIR   = 2'd2
	} op_kind_t;

	typedef struct packed {
		op_kind_t             kind;
		logic [LETTER_W-1:0]  letter;
		logic [PAIR_AW-1:0]   pair_addr;
		logic                 live;
	} op_t;

	typedef struct packed {
		logic                           clearing;
		logic                           valid_s1;
		logic [$clog2(OUT_DEPTH+1)-1:0] out_count;
	} back_stat_t;

	function automatic logic [COUNT_WIDTH-1:0] sat_inc(input logic [COUNT_WIDTH-1:0] v);
		return (&v) ? v : v + COUNT_WIDTH'(1);
	endfunction

	function automatic logic [OUT_WIDTH-1:0] clip_out(input logic [COUNT_WIDTH-1:0] v);
		logic [63:0] w;
		w = 64'(v);
		return (|w[63:OUT_WIDTH]) ? '1 : w[OUT_WIDTH-1:0];
	endfunction

endpackage

// File: hdl/lhd_ram.sv
module lhd_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 676
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

// File: hdl/lhd_front.sv
module lhd_front (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  logic [1:0]        cmd,
	input  logic [7:0]        data_byte,
	input  logic [4:0]        first_letter,
	input  logic [4:0]        second_letter,
	input  logic              block,
	output logic              full,
	output logic              q_push,
	output lhd_pkg::op_t      q_op
);

	logic                             accept;
	logic                             is_up;
	logic                             is_lo;
	logic                             is_letter;
	logic [lhd_pkg::LETTER_W-1:0]     idx;
	logic                             op_valid;
	logic [lhd_pkg::LETTER_W-1:0]     last_q;
	logic                             seen_q;

	always_comb begin
		full      = block;
		accept    = push && !block;
		is_up     = (data_byte >= lhd_pkg::CH_UP_A) && (data_byte <= lhd_pkg::CH_UP_Z);
		is_lo     = (data_byte >= lhd_pkg::CH_LO_A) && (data_byte <= lhd_pkg::CH_LO_Z);
		is_letter = is_up || is_lo;
		idx       = is_up ? lhd_pkg::LETTER_W'(data_byte - lhd_pkg::CH_UP_A)
		                  : lhd_pkg::LETTER_W'(data_byte - lhd_pkg::CH_LO_A);
		q_op      = '0;
		op_valid  = 1'b0;
		unique case (cmd)
			lhd_pkg::CMD_COUNT: begin
				op_valid       = is_letter;
				q_op.kind      = lhd_pkg::OP_BUMP;
				q_op.letter    = idx;
				q_op.pair_addr = lhd_pkg::PAIR_AW'(lhd_pkg::PAIR_AW'(last_q) *
				                 lhd_pkg::PAIR_AW'(lhd_pkg::ALPHA) + lhd_pkg::PAIR_AW'(idx));
				q_op.live      = seen_q;
			end
			lhd_pkg::CMD_RD_LETTER: begin
				op_valid    = 1'b1;
				q_op.kind   = lhd_pkg::OP_RD_LETTER;
				q_op.letter = first_letter;
				q_op.live   = 32'(first_letter) < lhd_pkg::ALPHA;
			end
			lhd_pkg::CMD_RD_PAIR: begin
				op_valid       = 1'b1;
				q_op.kind      = lhd_pkg::OP_RD_PAIR;
				q_op.pair_addr = lhd_pkg::PAIR_AW'(lhd_pkg::PAIR_AW'(first_letter) *
				                 lhd_pkg::PAIR_AW'(lhd_pkg::ALPHA) +
				                 lhd_pkg::PAIR_AW'(second_letter));
				q_op.live      = (32'(first_letter) < lhd_pkg::ALPHA) &&
				                 (32'(second_letter) < lhd_pkg::ALPHA);
			end
			default: begin
				op_valid = 1'b0;
			end
		endcase
		q_push = accept && op_valid;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_q <= '0;
			seen_q <= 1'b0;
		end else if (accept && (cmd == lhd_pkg::CMD_COUNT) && is_letter) begin
			last_q <= idx;
			seen_q <= 1'b1;
		end
	end

endmodule

// File: hdl/lhd_queue.sv
module lhd_queue (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  lhd_pkg::op_t  din,
	input  logic          pop,
	output lhd_pkg::op_t  dout,
	output logic          full,
	output logic          empty
);

	localparam int AW = $clog2(lhd_pkg::Q_DEPTH);
	localparam int CW = $clog2(lhd_pkg::Q_DEPTH + 1);

	lhd_pkg::op_t  mem_q [lhd_pkg::Q_DEPTH];
	logic [AW-1:0] wp_q;
	logic [AW-1:0] rp_q;
	logic [CW-1:0] cnt_q;
	logic          do_push;
	logic          do_pop;

	always_comb begin
		full    = 32'(cnt_q) == lhd_pkg::Q_DEPTH;
		empty   = cnt_q == '0;
		dout    = mem_q[rp_q];
		do_push = push && !full;
		do_pop  = pop && !empty;
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wp_q] <= din;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (do_push) begin
				wp_q <= wp_q + AW'(1);
			end
			if (do_pop) begin
				rp_q <= rp_q + AW'(1);
			end
			cnt_q <= cnt_q + CW'(do_push) - CW'(do_pop);
		end
	end

endmodule

// File: hdl/lhd_back.sv
module lhd_back (
	input  logic                            clk,
	input  logic                            arst_n,
	input  lhd_pkg::op_t                    q_op,
	input  logic                            q_empty,
	output logic                            q_pop,
	input  logic                            pop,
	output logic                            empty,
	output logic [lhd_pkg::OUT_WIDTH-1:0]   count_value,
	output lhd_pkg::back_stat_t             stat
);

	localparam int CW  = lhd_pkg::COUNT_WIDTH;
	localparam int AW  = lhd_pkg::PAIR_AW;
	localparam int OAW = $clog2(lhd_pkg::OUT_DEPTH);
	localparam int OCW = $clog2(lhd_pkg::OUT_DEPTH + 1);

	logic                          clr_q;
	logic [AW-1:0]                 clr_addr_q;
	logic                          valid_s1;
	lhd_pkg::op_t                  op_s1;
	logic                          wr_vld_q;
	logic [AW-1:0]                 wr_addr_q;
	logic [CW-1:0]                 wr_data_q;
	logic [CW-1:0]                 letter_q [lhd_pkg::ALPHA];
	logic [lhd_pkg::OUT_WIDTH-1:0] out_mem_q [lhd_pkg::OUT_DEPTH];
	logic [OAW-1:0]                out_wp_q;
	logic [OAW-1:0]                out_rp_q;
	logic [OCW-1:0]                out_cnt_q;

	logic                          rd_s1;
	logic                          bump_s1;
	logic                          room;
	logic [CW-1:0]                 ram_rdata;
	logic [CW-1:0]                 pair_cur;
	logic [CW-1:0]                 letter_cur;
	logic                          ram_we;
	logic [AW-1:0]                 ram_waddr;
	logic [CW-1:0]                 ram_wdata;
	logic                          pair_wr;
	logic [lhd_pkg::OUT_WIDTH-1:0] res;
	logic                          out_pop;

	lhd_ram #(
		.WIDTH (CW),
		.DEPTH (lhd_pkg::PAIR_DEPTH)
	) u_pair_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (q_op.pair_addr),
		.rdata (ram_rdata)
	);

	always_comb begin
		rd_s1   = valid_s1 && (op_s1.kind != lhd_pkg::OP_BUMP);
		bump_s1 = valid_s1 && (op_s1.kind == lhd_pkg::OP_BUMP);
		room    = ((OCW+1)'(out_cnt_q) + (OCW+1)'(rd_s1)) < (OCW+1)'(lhd_pkg::OUT_DEPTH);
		q_pop   = !q_empty && !clr_q && room;

		// last write has not reached the ram read port yet
		pair_cur   = (wr_vld_q && (wr_addr_q == op_s1.pair_addr)) ? wr_data_q : ram_rdata;
		letter_cur = letter_q[op_s1.letter];

		pair_wr   = bump_s1 && op_s1.live;
		ram_we    = clr_q || pair_wr;
		ram_waddr = clr_q ? clr_addr_q : op_s1.pair_addr;
		ram_wdata = clr_q ? '0 : lhd_pkg::sat_inc(pair_cur);

		unique case (op_s1.kind)
			lhd_pkg::OP_RD_LETTER: res = op_s1.live ? lhd_pkg::clip_out(letter_cur) : '0;
			lhd_pkg::OP_RD_PAIR:   res = op_s1.live ? lhd_pkg::clip_out(pair_cur) : '0;
			default:               res = '0;
		endcase

		empty       = out_cnt_q == '0;
		out_pop     = pop && !empty;
		count_value = out_mem_q[out_rp_q];

		stat.clearing  = clr_q;
		stat.valid_s1  = valid_s1;
		stat.out_count = out_cnt_q;
	end

	// pair counter clearing pass after reset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q      <= 1'b1;
			clr_addr_q <= '0;
		end else if (clr_q) begin
			clr_addr_q <= clr_addr_q + AW'(1);
			if (32'(clr_addr_q) == lhd_pkg::PAIR_DEPTH - 1) begin
				clr_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		op_s1 <= q_op;
		wr_addr_q <= op_s1.pair_addr;
		wr_data_q <= ram_wdata;
		if (rd_s1) begin
			out_mem_q[out_wp_q] <= res;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1  <= 1'b0;
			wr_vld_q  <= 1'b0;
			out_wp_q  <= '0;
			out_rp_q  <= '0;
			out_cnt_q <= '0;
			for (int i = 0; i < lhd_pkg::ALPHA; i++) begin
				letter_q[i] <= '0;
			end
		end else begin
			valid_s1 <= q_pop;
			wr_vld_q <= pair_wr && !clr_q;
			if (bump_s1) begin
				letter_q[op_s1.letter] <= lhd_pkg::sat_inc(letter_cur);
			end
			if (rd_s1) begin
				out_wp_q <= out_wp_q + OAW'(1);
			end
			if (out_pop) begin
				out_rp_q <= out_rp_q + OAW'(1);
			end
			out_cnt_q <= out_cnt_q + OCW'(rd_s1) - OCW'(out_pop);
		end
	end

endmodule

// File: hdl/letter_digraph_histogram_top.sv
// read path: with both queues empty a read beat taken by push passes the op queue, then
// op_s1 and the result queue before it shows on count_value; count beats give no result
// throughput: one beat per cycle while full stays low, set by the pair ram read-update-write
// with a write bypass; reset: all counters read zero; full stays high while all 676
// pair ram entries are cleared, one entry a cycle
module letter_digraph_histogram_top (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          push,
	output logic                          full,
	input  logic [1:0]                    cmd,
	input  logic [7:0]                    data_byte,
	input  logic [4:0]                    first_letter,
	input  logic [4:0]                    second_letter,
	output logic                          empty,
	input  logic                          pop,
	output logic [lhd_pkg::OUT_WIDTH-1:0] count_value
);

	logic                 q_full;
	logic                 q_empty;
	logic                 q_push;
	logic                 q_pop;
	lhd_pkg::op_t         q_din;
	lhd_pkg::op_t         q_dout;
	lhd_pkg::back_stat_t  stat;

	lhd_front u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.push          (push),
		.cmd           (cmd),
		.data_byte     (data_byte),
		.first_letter  (first_letter),
		.second_letter (second_letter),
		.block         (q_full || stat.clearing),
		.full          (full),
		.q_push        (q_push),
		.q_op          (q_din)
	);

	lhd_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (q_push),
		.din    (q_din),
		.pop    (q_pop),
		.dout   (q_dout),
		.full   (q_full),
		.empty  (q_empty)
	);

	lhd_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.q_op        (q_dout),
		.q_empty     (q_empty),
		.q_pop       (q_pop),
		.pop         (pop),
		.empty       (empty),
		.count_value (count_value),
		.stat        (stat)
	);

	a_out_bound: assert property (@(posedge clk) disable iff (!arst_n)
		32'(stat.out_count) <= lhd_pkg::OUT_DEPTH)
		else $error("result queue overrun");

	a_clear_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		stat.clearing |-> (q_empty && !stat.valid_s1 && full))
		else $error("beat in flight during clearing pass");

	a_no_pop_clear: assert property (@(posedge clk) disable iff (!arst_n)
		stat.clearing |=> !stat.valid_s1)
		else $error("pair ram used before clearing done");

endmodule

// File: tb/sv/histogram_checker.sv
`timescale 1ns / 100ps

module histogram_checker
	import lhd_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 push,
	input  logic                 full,
	input  logic [1:0]           cmd,
	input  logic [7:0]           data_byte,
	input  logic [4:0]           first_letter,
	input  logic [4:0]           second_letter,
	input  logic                 empty,
	input  logic                 pop,
	input  logic [OUT_WIDTH-1:0] count_value,
	output int                   fails,
	output int                   waiting
);

	typedef logic [COUNT_WIDTH-1:0] tally_t;

	tally_t              letter_tally [ALPHA];
	tally_t              pair_tally   [PAIR_DEPTH];
	logic [LETTER_W-1:0] prev_letter;
	logic                have_prev;

	logic [OUT_WIDTH-1:0] expected_counts [$];
	int                   mismatches;

	initial begin
		for (int i = 0; i < ALPHA; i++)
			letter_tally[i] = '0;
		for (int i = 0; i < PAIR_DEPTH; i++)
			pair_tally[i] = '0;
		prev_letter = '0;
		have_prev   = 1'b0;
		mismatches  = 0;
	end

	function automatic logic [OUT_WIDTH-1:0] clip_read(input tally_t v);
		logic [63:0] w;
		w = 64'(v);
		return (w > 64'hFFFF_FFFF) ? '1 : w[OUT_WIDTH-1:0];
	endfunction

	// updates the tallies for a count beat, gives the read value for a read beat
	function automatic bit predict_count(input logic [1:0] c, input logic [7:0] b,
		input logic [4:0] f, input logic [4:0] s, output logic [OUT_WIDTH-1:0] v);
		int idx;
		int pidx;
		v = '0;
		case (c)
			CMD_COUNT: begin
				if (b >= CH_UP_A && b <= CH_UP_Z)
					idx = b - CH_UP_A;
				else if (b >= CH_LO_A && b <= CH_LO_Z)
					idx = b - CH_LO_A;
				else
					return 1'b0;
				if (have_prev) begin
					pidx = prev_letter * ALPHA + idx;
					if (!(&pair_tally[pidx]))
						pair_tally[pidx] = pair_tally[pidx] + 1'b1;
				end
				if (!(&letter_tally[idx]))
					letter_tally[idx] = letter_tally[idx] + 1'b1;
				prev_letter = LETTER_W'(idx);
				have_prev   = 1'b1;
				return 1'b0;
			end
			CMD_RD_LETTER: begin
				if (f < ALPHA)
					v = clip_read(letter_tally[f]);
				return 1'b1;
			end
			CMD_RD_PAIR: begin
				if (f < ALPHA && s < ALPHA)
					v = clip_read(pair_tally[f * ALPHA + s]);
				return 1'b1;
			end
			default: return 1'b0;
		endcase
	endfunction

	always @(posedge clk) begin : watch
		logic [OUT_WIDTH-1:0] want;
		logic [OUT_WIDTH-1:0] read_value;
		if (arst_n) begin
			if (pop && !empty) begin
				if (expected_counts.size() == 0) begin
					if (mismatches < 10)
						$display("%0t: result beat with no read pending, count_value %0d",
							$realtime, count_value);
					mismatches++;
				end else begin
					want = expected_counts.pop_front();
					if (count_value !== want) begin
						if (mismatches < 10)
							$display("%0t: count_value mismatch, expected %0d, actual %0d",
								$realtime, want, count_value);
						mismatches++;
					end
				end
			end
			if (push && !full) begin
				if (predict_count(cmd, data_byte, first_letter, second_letter, read_value))
					expected_counts.push_back(read_value);
			end
		end
		fails   <= mismatches;
		waiting <= expected_counts.size();
	end

endmodule

// File: tb/sv/testbench.sv
`timescale 1ns / 100ps

module testbench;

	import lhd_pkg::*;

	localparam logic [1:0] CMD_IGNORED = 2'd3;
	localparam int         N_RANDOM    = 1450;

	logic       clk           = 1'b0;
	logic       arst_n        = 1'b0;
	logic       push          = 1'b0;
	logic [1:0] cmd           = CMD_COUNT;
	logic [7:0] data_byte     = 8'd0;
	logic [4:0] first_letter  = 5'd0;
	logic [4:0] second_letter = 5'd0;
	logic       pop           = 1'b0;

	logic                 full;
	logic                 empty;
	logic [OUT_WIDTH-1:0] count_value;

	int fails;
	int waiting;
	int n_letters;
	int n_ignored;
	int n_letter_reads;
	int n_pair_reads;

	always #1 clk = ~clk;

	letter_digraph_histogram_top DUT (
		.clk           (clk),
		.arst_n        (arst_n),
		.push          (push),
		.full          (full),
		.cmd           (cmd),
		.data_byte     (data_byte),
		.first_letter  (first_letter),
		.second_letter (second_letter),
		.empty         (empty),
		.pop           (pop),
		.count_value   (count_value)
	);

	histogram_checker u_hist_check (
		.clk           (clk),
		.arst_n        (arst_n),
		.push          (push),
		.full          (full),
		.cmd           (cmd),
		.data_byte     (data_byte),
		.first_letter  (first_letter),
		.second_letter (second_letter),
		.empty         (empty),
		.pop           (pop),
		.count_value   (count_value),
		.fails         (fails),
		.waiting       (waiting)
	);

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 60)
			return 0;
		if (r < 88)
			return $urandom_range(1, 3);
		if (r < 97)
			return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	function automatic bit is_letter(input logic [7:0] b);
		return (b >= CH_UP_A && b <= CH_UP_Z) || (b >= CH_LO_A && b <= CH_LO_Z);
	endfunction

	function automatic logic [7:0] letter_char(input int idx, input bit upper);
		return (upper ? CH_UP_A : CH_LO_A) + 8'(idx);
	endfunction

	task automatic push_beat(input logic [1:0] c, input logic [7:0] b,
		input logic [4:0] f, input logic [4:0] s);
		int gap;
		push          <= 1'b1;
		cmd           <= c;
		data_byte     <= b;
		first_letter  <= f;
		second_letter <= s;
		do @(posedge clk); while (full);
		case (c)
			CMD_COUNT:     if (is_letter(b)) n_letters++; else n_ignored++;
			CMD_RD_LETTER: n_letter_reads++;
			CMD_RD_PAIR:   n_pair_reads++;
			default:       n_ignored++;
		endcase
		gap = pick_gap();
		if (gap > 0) begin
			push <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	task automatic push_letter(input int idx, input bit upper);
		push_beat(CMD_COUNT, letter_char(idx, upper), 5'($urandom), 5'($urandom));
	endtask

	task automatic drain_reads();
		push <= 1'b0;
		do @(posedge clk); while (waiting != 0);
	endtask

	initial begin
		int r;
		int idx;
		int f;
		int s;
		bit paused;
		n_letters      = 0;
		n_ignored      = 0;
		n_letter_reads = 0;
		n_pair_reads   = 0;
		paused         = 1'b0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reads straight after reset
		push_beat(CMD_RD_LETTER, 8'hff, 5'd0, 5'd31);
		push_beat(CMD_RD_LETTER, 8'h00, 5'd25, 5'd0);
		push_beat(CMD_RD_PAIR, 8'h41, 5'd0, 5'd0);
		push_beat(CMD_RD_PAIR, 8'h7a, 5'd25, 5'd25);
		// letter range edges, both cases
		push_letter(0, 1'b1);
		push_letter(25, 1'b0);
		push_letter(25, 1'b1);
		push_letter(0, 1'b0);
		// bytes just outside the letter ranges do not break a pair
		push_beat(CMD_COUNT, CH_UP_A - 8'd1, 5'd31, 5'd31);
		push_beat(CMD_COUNT, CH_UP_Z + 8'd1, 5'd0, 5'd0);
		push_beat(CMD_COUNT, CH_LO_A - 8'd1, 5'd31, 5'd0);
		push_beat(CMD_COUNT, CH_LO_Z + 8'd1, 5'd0, 5'd31);
		push_beat(CMD_COUNT, 8'h00, 5'd0, 5'd0);
		push_beat(CMD_COUNT, 8'hff, 5'd31, 5'd31);
		push_letter(0, 1'b1);
		push_beat(CMD_IGNORED, CH_UP_A, 5'd31, 5'd31);
		push_beat(CMD_RD_LETTER, 8'h00, 5'd0, 5'd0);
		push_beat(CMD_RD_LETTER, 8'hff, 5'd25, 5'd31);
		push_beat(CMD_RD_LETTER, 8'h00, 5'd26, 5'd0);
		push_beat(CMD_RD_LETTER, 8'h00, 5'd31, 5'd0);
		push_beat(CMD_RD_PAIR, 8'h00, 5'd0, 5'd25);
		push_beat(CMD_RD_PAIR, 8'h00, 5'd25, 5'd0);
		push_beat(CMD_RD_PAIR, 8'h00, 5'd0, 5'd0);
		push_beat(CMD_RD_PAIR, 8'h00, 5'd31, 5'd0);
		push_beat(CMD_RD_PAIR, 8'h00, 5'd0, 5'd31);
		push_beat(CMD_RD_PAIR, 8'hff, 5'd26, 5'd26);

		while (n_letters + n_ignored + n_letter_reads + n_pair_reads < N_RANDOM) begin
			if (!paused &&
			    n_letters + n_ignored + n_letter_reads + n_pair_reads > N_RANDOM / 2) begin
				drain_reads();
				paused = 1'b1;
			end
			r = $urandom_range(0, 99);
			if (r < 62) begin
				// letters 0 to 3 come up far more often than the rest so their pair counters climb
				idx = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 3) : $urandom_range(0, 25);
				push_letter(idx, 1'($urandom));
			end else if (r < 70) begin
				push_beat(CMD_COUNT, 8'($urandom), 5'($urandom), 5'($urandom));
			end else if (r < 82) begin
				f = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 31) : $urandom_range(0, 25);
				push_beat(CMD_RD_LETTER, 8'($urandom), 5'(f), 5'($urandom));
			end else if (r < 97) begin
				if ($urandom_range(0, 9) == 0) begin
					f = $urandom_range(0, 31);
					s = $urandom_range(0, 31);
				end else if ($urandom_range(0, 1) == 0) begin
					f = $urandom_range(0, 3);
					s = $urandom_range(0, 3);
				end else begin
					f = $urandom_range(0, 25);
					s = $urandom_range(0, 25);
				end
				push_beat(CMD_RD_PAIR, 8'($urandom), 5'(f), 5'(s));
			end else begin
				push_beat(CMD_IGNORED, 8'($urandom), 5'($urandom), 5'($urandom));
			end
		end

		drain_reads();
		repeat (20) @(posedge clk);
		$display("covered %0d letters counted and %0d skipped bytes or ignored commands,",
			n_letters, n_ignored);
		$display("with %0d letter reads and %0d pair reads checked in order",
			n_letter_reads, n_pair_reads);
		if (fails == 0 && waiting == 0) begin
			$display("All tests passed");
		end else begin
			$display("Some tests failed");
		end
		$finish;
	end

	initial begin
		int run;
		int gap;
		@(posedge arst_n);
		forever begin
			pop <= 1'b1;
			run = ($urandom_range(0, 9) == 0) ? $urandom_range(50, 200) : $urandom_range(1, 8);
			repeat (run) @(posedge clk);
			gap = pick_gap();
			if (gap > 0) begin
				pop <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
	end

	initial begin
		#1_000_000;
		$display("Some tests failed");
		$finish;
	end

endmodule
